>>> design/ati_pkg.sv
// Shared types and constants for the adaptive threshold integral core.
// Frame limits, field widths, register indexes and the integral store request structs.
// Depends on nothing; every module of the core imports it.
`default_nettype none

package ati_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int XW    = COL_W + 1;
    localparam int YW    = ROW_W + 1;
    localparam int MXY   = (XW > YW) ? XW : YW;

    localparam int CFG_W     = 9;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 4;
    localparam int EW        = ((MXY > CFG_W) ? MXY : CFG_W) + 1;

    localparam int PIX_W  = 8;
    localparam int IW     = 24;
    localparam int RS_W   = 16;
    localparam int CNT_W  = COL_W + ROW_W;
    localparam int PROD_W = CNT_W + PIX_W;
    localparam int LHS_W  = PROD_W + 1 + PCT_W;
    localparam int RHS_W  = IW + PCT_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    localparam int MEM_AW    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
    localparam logic [PIX_W-1:0] PIX_WHITE = PIX_W'(255);
    localparam logic [PIX_W-1:0] PIX_BLACK = PIX_W'(0);

    localparam logic [CFG_W-1:0] RST_WIDTH   = CFG_W'(256);
    localparam logic [CFG_W-1:0] RST_HEIGHT  = CFG_W'(256);
    localparam logic [CFG_W-1:0] RST_WINDOW  = CFG_W'(32);
    localparam logic [PCT_W-1:0] RST_PERCENT = PCT_W'(15);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT = CFG_IDX_W'(3);

    typedef struct packed {
        logic          en;
        logic [YW-1:0] y_a;
        logic [XW-1:0] x_a;
        logic [YW-1:0] y_b;
        logic [XW-1:0] x_b;
    } t_ist_rd;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [IW-1:0]    data;
    } t_ist_wr;

endpackage

`default_nettype wire

>>> design/adaptive_threshold_integral_core.sv
// Adaptive threshold core: frame load with integral image build, then local-mean threshold.
// Instantiates ati_istore; depends on ati_pkg.
//
// A load request (func 0) stores one pixel in raster order: one integral store read of the
// row above, then the write of the new integral entry. Once the frame is complete, each
// emit request (func 1) goes from acceptance to the result register through the pixel read,
// paired reads in S_EM_RD1 and S_EM_RD2 on the dual-read integral store for the four window
// corners, then sum and count products, the scaled compare, and the output load.
// One request is in flight at a time; a finished result waits in the output register while
// the next request is accepted. Loads while a frame is held and emits before the frame is
// complete are accepted and dropped. Each write to a defined register index restarts loading
// from the first pixel with no frame held. No clearing pass is needed after reset.
`default_nettype none

module adaptive_threshold_integral_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_func,
    input  wire  [ati_pkg::PIX_W-1:0]        i_gray_pixel,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [ati_pkg::PIX_W-1:0]        o_binary_pixel,
    output logic                             o_frame_last,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [ati_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [ati_pkg::CFG_W-1:0]        i_cfg_data
);
    import ati_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_LOAD_WR = 7'b0000010,
        S_EM_RD1  = 7'b0000100,
        S_EM_RD2  = 7'b0001000,
        S_EM_SUM  = 7'b0010000,
        S_EM_MUL  = 7'b0100000,
        S_EM_OUT  = 7'b1000000
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CFG_W-1:0] r_window;
    logic [PCT_W-1:0] r_percent;

    logic [ROW_W-1:0] r_load_row;
    logic [COL_W-1:0] r_load_col;
    logic [ROW_W-1:0] r_emit_row;
    logic [COL_W-1:0] r_emit_col;
    logic             r_frame_loaded;
    logic [RS_W-1:0]  r_row_sum;

    logic [ROW_W-1:0] r_wr_row;
    logic [COL_W-1:0] r_wr_col;
    logic [XW-1:0]    r_x1;
    logic [XW-1:0]    r_x2;
    logic [YW-1:0]    r_y1;
    logic [YW-1:0]    r_y2;
    logic [PIX_W-1:0] r_pix_q;
    logic [IW-1:0]    r_q0;
    logic [IW-1:0]    r_sum;
    logic [CNT_W-1:0] r_count;
    logic [PROD_W-1:0] r_prod;
    logic [CMP_W-1:0] r_lhs;
    logic [CMP_W-1:0] r_rhs;

    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_last;
    logic             r_out_valid;

    logic [PIX_W-1:0] m_pix [MEM_DEPTH];

    logic             in_acc;
    logic             ld_acc;
    logic             em_acc;
    logic             out_free;
    logic             cfg_hit;
    logic [XW-1:0]    w_eff;
    logic [YW-1:0]    h_eff;
    logic [XW-1:0]    w_m1;
    logic [YW-1:0]    h_m1;
    logic             ld_col_end;
    logic             ld_row_end;
    logic             em_col_end;
    logic             em_row_end;
    logic [RS_W-1:0]  n_row_sum;
    logic [EW-1:0]    s2;
    logic [EW-1:0]    ec;
    logic [EW-1:0]    er;
    logic [EW-1:0]    x_hi;
    logic [EW-1:0]    y_hi;
    logic [XW-1:0]    n_x1;
    logic [XW-1:0]    n_x2;
    logic [YW-1:0]    n_y1;
    logic [YW-1:0]    n_y2;
    logic [XW-1:0]    dx;
    logic [YW-1:0]    dy;
    logic [PCT_W-1:0] factor;

    t_ist_rd          ist_rd;
    t_ist_wr          ist_wr;
    logic [IW-1:0]    ist_q_a;
    logic [IW-1:0]    ist_q_b;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_binary_pixel = r_out_pixel;
    assign o_frame_last   = r_out_last;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign ld_acc   = in_acc && !i_func && !r_frame_loaded;
    assign em_acc   = in_acc && i_func && r_frame_loaded;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_hit  = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (r_width == '0) begin
            w_eff = XW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = YW'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            h_eff = YW'(MAX_HEIGHT);
        end else begin
            h_eff = YW'(r_height);
        end
        w_m1 = w_eff - XW'(1);
        h_m1 = h_eff - YW'(1);

        ld_col_end = XW'(r_load_col) >= w_m1;
        ld_row_end = YW'(r_load_row) >= h_m1;
        em_col_end = XW'(r_emit_col) >= w_m1;
        em_row_end = YW'(r_emit_row) >= h_m1;

        n_row_sum = ((r_load_col == '0) ? '0 : r_row_sum) + RS_W'(i_gray_pixel);

        s2   = EW'(r_window >> 1);
        ec   = EW'(r_emit_col);
        er   = EW'(r_emit_row);
        x_hi = ec + s2;
        y_hi = er + s2;
        n_x2 = (x_hi > EW'(w_m1)) ? w_m1 : XW'(x_hi);
        n_y2 = (y_hi > EW'(h_m1)) ? h_m1 : YW'(y_hi);
        n_x1 = (ec >= s2) ? XW'(ec - s2) : '0;
        n_y1 = (er >= s2) ? YW'(er - s2) : '0;

        dx     = r_x2 - r_x1;
        dy     = r_y2 - r_y1;
        factor = (r_percent < PCT_FULL) ? (PCT_FULL - r_percent) : '0;
    end

    always_comb begin
        ist_rd = '0;
        if (ld_acc) begin
            ist_rd.en  = 1'b1;
            ist_rd.y_a = YW'(r_load_row);
            ist_rd.x_a = XW'(r_load_col) + XW'(1);
            ist_rd.y_b = YW'(r_load_row);
            ist_rd.x_b = XW'(r_load_col) + XW'(1);
        end else if (r_state == S_EM_RD1) begin
            ist_rd.en  = 1'b1;
            ist_rd.y_a = r_y2;
            ist_rd.x_a = r_x2;
            ist_rd.y_b = r_y1;
            ist_rd.x_b = r_x1;
        end else if (r_state == S_EM_RD2) begin
            ist_rd.en  = 1'b1;
            ist_rd.y_a = r_y1;
            ist_rd.x_a = r_x2;
            ist_rd.y_b = r_y2;
            ist_rd.x_b = r_x1;
        end
        ist_wr.en   = (r_state == S_LOAD_WR);
        ist_wr.row  = r_wr_row;
        ist_wr.col  = r_wr_col;
        ist_wr.data = ist_q_a + IW'(r_row_sum);
    end

    ati_istore u_istore (
        .i_clk  (i_clk),
        .i_rd   (ist_rd),
        .i_wr   (ist_wr),
        .o_rd_a (ist_q_a),
        .o_rd_b (ist_q_b)
    );

    // pixel store
    always_ff @(posedge i_clk) begin
        if (ld_acc) begin
            m_pix[{r_load_row, r_load_col}] <= i_gray_pixel;
        end
        if (em_acc) begin
            r_pix_q <= m_pix[{r_emit_row, r_emit_col}];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (ld_acc) begin
            r_wr_row <= r_load_row;
            r_wr_col <= r_load_col;
        end
        if (em_acc) begin
            r_x1 <= n_x1;
            r_x2 <= n_x2;
            r_y1 <= n_y1;
            r_y2 <= n_y2;
        end
        if (r_state == S_EM_RD2) begin
            r_q0    <= ist_q_a + ist_q_b;
            r_count <= CNT_W'(dx[COL_W-1:0]) * CNT_W'(dy[ROW_W-1:0]);
        end
        if (r_state == S_EM_SUM) begin
            r_sum  <= r_q0 - ist_q_a - ist_q_b;
            r_prod <= PROD_W'(r_pix_q) * PROD_W'(r_count);
        end
        if (r_state == S_EM_MUL) begin
            r_lhs <= CMP_W'((LHS_W'(r_prod) + LHS_W'(1)) * LHS_W'(PCT_FULL));
            r_rhs <= CMP_W'(RHS_W'(r_sum) * RHS_W'(factor));
        end
        if ((r_state == S_EM_OUT) && out_free) begin
            r_out_pixel <= (r_lhs <= r_rhs) ? PIX_WHITE : PIX_BLACK;
            r_out_last  <= em_col_end && em_row_end;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_width        <= RST_WIDTH;
            r_height       <= RST_HEIGHT;
            r_window       <= RST_WINDOW;
            r_percent      <= RST_PERCENT;
            r_load_row     <= '0;
            r_load_col     <= '0;
            r_emit_row     <= '0;
            r_emit_col     <= '0;
            r_frame_loaded <= 1'b0;
            r_row_sum      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (ld_acc) begin
                        r_row_sum <= n_row_sum;
                        r_state   <= S_LOAD_WR;
                        if (ld_col_end) begin
                            r_load_col <= '0;
                            if (ld_row_end) begin
                                r_load_row     <= '0;
                                r_frame_loaded <= 1'b1;
                            end else begin
                                r_load_row <= r_load_row + ROW_W'(1);
                            end
                        end else begin
                            r_load_col <= r_load_col + COL_W'(1);
                        end
                    end else if (em_acc) begin
                        r_state <= S_EM_RD1;
                    end
                end
                S_LOAD_WR: r_state <= S_IDLE;
                S_EM_RD1:  r_state <= S_EM_RD2;
                S_EM_RD2:  r_state <= S_EM_SUM;
                S_EM_SUM:  r_state <= S_EM_MUL;
                S_EM_MUL:  r_state <= S_EM_OUT;
                S_EM_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (em_col_end) begin
                            r_emit_col <= '0;
                            if (em_row_end) begin
                                r_emit_row     <= '0;
                                r_frame_loaded <= 1'b0;
                            end else begin
                                r_emit_row <= r_emit_row + ROW_W'(1);
                            end
                        end else begin
                            r_emit_col <= r_emit_col + COL_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (cfg_hit) begin
                case (i_cfg_index)
                    CFG_WIDTH:   r_width   <= i_cfg_data;
                    CFG_HEIGHT:  r_height  <= i_cfg_data;
                    CFG_WINDOW:  r_window  <= i_cfg_data;
                    CFG_PERCENT: r_percent <= i_cfg_data[PCT_W-1:0];
                    default: ;
                endcase
                if (i_cfg_index inside {CFG_WIDTH, CFG_HEIGHT, CFG_WINDOW, CFG_PERCENT}) begin
                    r_load_row     <= '0;
                    r_load_col     <= '0;
                    r_emit_row     <= '0;
                    r_emit_col     <= '0;
                    r_frame_loaded <= 1'b0;
                    r_row_sum      <= '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/ati_istore.sv
// Integral image store: one write port and two registered read ports.
// Row zero and column zero of the integral image are never stored and read as zero.
// Depends on ati_pkg.
`default_nettype none

module ati_istore (
    input  wire                       i_clk,
    input  wire ati_pkg::t_ist_rd     i_rd,
    input  wire ati_pkg::t_ist_wr     i_wr,
    output logic [ati_pkg::IW-1:0]    o_rd_a,
    output logic [ati_pkg::IW-1:0]    o_rd_b
);
    import ati_pkg::*;

    logic [IW-1:0] m_int [MEM_DEPTH];

    logic [IW-1:0]     r_q_a;
    logic [IW-1:0]     r_q_b;
    logic              r_zero_a;
    logic              r_zero_b;
    logic [YW-1:0]     ya_m1;
    logic [XW-1:0]     xa_m1;
    logic [YW-1:0]     yb_m1;
    logic [XW-1:0]     xb_m1;
    logic [MEM_AW-1:0] addr_a;
    logic [MEM_AW-1:0] addr_b;

    always_comb begin
        ya_m1  = i_rd.y_a - YW'(1);
        xa_m1  = i_rd.x_a - XW'(1);
        yb_m1  = i_rd.y_b - YW'(1);
        xb_m1  = i_rd.x_b - XW'(1);
        addr_a = {ya_m1[ROW_W-1:0], xa_m1[COL_W-1:0]};
        addr_b = {yb_m1[ROW_W-1:0], xb_m1[COL_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            m_int[{i_wr.row, i_wr.col}] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q_a    <= m_int[addr_a];
            r_q_b    <= m_int[addr_b];
            r_zero_a <= (i_rd.y_a == '0) || (i_rd.x_a == '0);
            r_zero_b <= (i_rd.y_b == '0) || (i_rd.x_b == '0);
        end
    end

    assign o_rd_a = r_zero_a ? '0 : r_q_a;
    assign o_rd_b = r_zero_b ? '0 : r_q_b;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for adaptive_threshold_integral_core: frame loads, thresholded emits, register writes.
// Holds a scoreboard class that tracks the integral image and predicts each binary pixel.
// Depends on ati_pkg and the core RTL only.

module tb_top;
    import ati_pkg::*;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_EMIT     = 1'b1;
    localparam int   I_STRIDE      = MAX_WIDTH + 1;
    localparam int   INDEX_COUNT   = 4;
    localparam int   INDEX_TOP     = (1 << CFG_IDX_W) - 1;
    localparam int   ITEM_BUDGET   = 1350;
    localparam int   CYCLE_LIMIT   = 250000;
    localparam int   HOLD_CYCLES   = 200;
    localparam int   SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_thr_result;

    class t_threshold_scoreboard;
        bit [CFG_W-1:0] width_reg, height_reg, window_reg;
        bit [PCT_W-1:0] pct_reg;
        bit [IW-1:0]    integral [(MAX_WIDTH + 1) * (MAX_HEIGHT + 1)];
        bit [PIX_W-1:0] frame_pix [MAX_WIDTH * MAX_HEIGHT];
        bit [RS_W-1:0]  row_sum;
        int unsigned    ld_row, ld_col, em_row, em_col;
        bit             frame_held;
        t_thr_result    awaited_pixels[$];
        int             errors, pixels_checked, frames_done;

        function void restart();
            row_sum    = '0;
            ld_row     = 0;
            ld_col     = 0;
            em_row     = 0;
            em_col     = 0;
            frame_held = 1'b0;
        endfunction

        function void reset_state();
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            window_reg = RST_WINDOW;
            pct_reg    = RST_PERCENT;
            restart();
        endfunction

        function int unsigned cols();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned rows();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_WIDTH:   width_reg = data;
                CFG_HEIGHT:  height_reg = data;
                CFG_WINDOW:  window_reg = data;
                CFG_PERCENT: pct_reg = data[PCT_W-1:0];
                default:     return;
            endcase
            restart();
        endfunction

        function void note_request(logic func, logic [PIX_W-1:0] px);
            int unsigned       w, h, half, x1, x2, y1, y2, count, sum, factor;
            longint unsigned   pv, lhs, rhs;
            t_thr_result       r;
            w = cols();
            h = rows();
            if (func == FUNC_LOAD) begin
                if (frame_held) return;
                frame_pix[ld_row * MAX_WIDTH + ld_col] = px;
                if (ld_col == 0) row_sum = '0;
                row_sum = row_sum + px;
                integral[(ld_row + 1) * I_STRIDE + ld_col + 1] =
                    integral[ld_row * I_STRIDE + ld_col + 1] + row_sum;
                if (ld_col + 1 >= w) begin
                    ld_col = 0;
                    if (ld_row + 1 >= h) begin
                        ld_row     = 0;
                        frame_held = 1'b1;
                    end else begin
                        ld_row++;
                    end
                end else begin
                    ld_col++;
                end
                return;
            end
            if (!frame_held) return;
            half = window_reg >> 1;
            x1 = (em_col >= half) ? em_col - half : 0;
            x2 = em_col + half;
            if (x2 > w - 1) x2 = w - 1;
            y1 = (em_row >= half) ? em_row - half : 0;
            y2 = em_row + half;
            if (y2 > h - 1) y2 = h - 1;
            count = (x2 - x1) * (y2 - y1);
            sum = integral[y2 * I_STRIDE + x2] + integral[y1 * I_STRIDE + x1]
                - integral[y1 * I_STRIDE + x2] - integral[y2 * I_STRIDE + x1];
            factor = (pct_reg < PCT_FULL) ? PCT_FULL - pct_reg : 0;
            pv  = frame_pix[em_row * MAX_WIDTH + em_col];
            lhs = PCT_FULL * (pv * count + 1);
            rhs = longint'(sum) * factor;
            r.pixel = (lhs <= rhs) ? PIX_WHITE : PIX_BLACK;
            r.last  = (em_col + 1 >= w) && (em_row + 1 >= h);
            awaited_pixels.push_back(r);
            if (em_col + 1 >= w) begin
                em_col = 0;
                if (r.last) begin
                    em_row     = 0;
                    frame_held = 1'b0;
                end else begin
                    em_row++;
                end
            end else begin
                em_col++;
            end
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pixel, logic last);
            t_thr_result e;
            if (awaited_pixels.size() == 0) begin
                $error("unexpected result: binary_pixel %0d frame_last %0b", pixel, last);
                errors++;
                return;
            end
            e = awaited_pixels.pop_front();
            pixels_checked++;
            if (e.last) frames_done++;
            if (pixel !== e.pixel) begin
                $error("binary_pixel expected %0d actual %0d", e.pixel, pixel);
                errors++;
            end
            if (last !== e.last) begin
                $error("frame_last expected %0b actual %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_func;
    logic [PIX_W-1:0]     i_gray_pixel;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [PIX_W-1:0]     o_binary_pixel;
    logic                 o_frame_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    t_threshold_scoreboard sb;
    bit calm = 1'b0;
    bit hold_results = 1'b0;
    bit hold_done = 1'b0;
    int ordinary_reqs = 0;
    int cfg_writes = 0;
    int cycles = 0;

    adaptive_threshold_integral_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_gray_pixel   (i_gray_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_binary_pixel (o_binary_pixel),
        .o_frame_last   (o_frame_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_pixel(o_binary_pixel, o_frame_last);
        end
    end

    initial begin : result_sink
        int k;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                i_out_stall <= 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
                hold_results = 1'b0;
            end
            i_out_stall <= !calm && ($urandom_range(99) < 14);
        end
    end

    task automatic send(input logic func, input logic [PIX_W-1:0] px);
        int gap;
        if (!calm && $urandom_range(99) < 14) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_gray_pixel <= px;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(func, px);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_frame(output bit cut_short);
        int unsigned n, stop, k;
        n = sb.cols() * sb.rows();
        cut_short = hold_done && ($urandom_range(99) < 8);
        stop = cut_short ? $urandom_range(0, 2 * n - 1) : 2 * n;
        for (k = 0; k < stop; k++) begin
            if (k < n) begin
                if ($urandom_range(99) < 4) send(FUNC_EMIT, PIX_W'($urandom_range(0, 255)));
                if (k == n / 2 && $urandom_range(99) < 15) begin
                    write_reg(CFG_IDX_W'($urandom_range(INDEX_COUNT, INDEX_TOP)),
                              CFG_W'($urandom));
                end
                send(FUNC_LOAD, PIX_W'($urandom_range(0, 255)));
            end else begin
                if (k == n) begin
                    if ($urandom_range(99) < 20) send(FUNC_LOAD, PIX_W'($urandom_range(0, 255)));
                    if (!hold_done && n >= 8) begin
                        hold_results = 1'b1;
                        hold_done    = 1'b1;
                    end
                end
                send(FUNC_EMIT, PIX_W'($urandom_range(0, 255)));
            end
            ordinary_reqs++;
        end
    endtask

    task automatic configure_phase(input int phase);
        logic [CFG_W-1:0] w, h;
        if (phase == 1) begin
            w = CFG_W'($urandom_range(MAX_WIDTH, (1 << CFG_W) - 1));
            h = CFG_W'($urandom_range(0, 1));
        end else if (phase == 4) begin
            w = CFG_W'($urandom_range(0, 1));
            h = CFG_W'($urandom_range(MAX_HEIGHT, (1 << CFG_W) - 1));
        end else begin
            w = CFG_W'($urandom_range(0, 8));
            h = CFG_W'($urandom_range(0, 8));
        end
        if ($urandom_range(99) < 10) begin
            write_reg(CFG_IDX_W'($urandom_range(INDEX_COUNT, INDEX_TOP)), CFG_W'($urandom));
        end
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        if ($urandom_range(99) < 60) begin
            write_reg(CFG_WINDOW, CFG_W'(($urandom_range(99) < 70) ? $urandom_range(0, 20)
                                                                    : $urandom_range(0, 511)));
        end
        if ($urandom_range(99) < 60) begin
            write_reg(CFG_PERCENT, CFG_W'(($urandom_range(99) < 70) ? $urandom_range(0, 40)
                                                                     : $urandom_range(0, 127)));
        end
    endtask

    initial begin : stimulus
        int phase;
        int frames;
        int f;
        bit cut;
        sb = new();
        sb.reset_state();
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_func       <= FUNC_LOAD;
        i_gray_pixel <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_WIDTH;
        i_cfg_data   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_HEIGHT, 2);
        write_reg(CFG_WINDOW, 4);
        write_reg(CFG_PERCENT, 0);
        send(FUNC_EMIT, 8'hA5);
        send(FUNC_LOAD, 255);
        send(FUNC_LOAD, 0);
        send(FUNC_LOAD, 0);
        send(FUNC_LOAD, 255);
        send(FUNC_LOAD, 8'h5A);
        repeat (4) send(FUNC_EMIT, 0);

        write_reg(CFG_WIDTH, 0);
        write_reg(CFG_HEIGHT, 3);
        write_reg(CFG_WINDOW, 1);
        write_reg(CFG_PERCENT, 127);
        send(FUNC_LOAD, 255);
        send(FUNC_LOAD, 0);
        send(FUNC_LOAD, 128);
        repeat (3) send(FUNC_EMIT, 8'hFF);

        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_HEIGHT, 2);
        write_reg(CFG_WINDOW, 2);
        write_reg(CFG_PERCENT, 100);
        send(FUNC_LOAD, 200);
        send(FUNC_LOAD, 10);
        send(FUNC_LOAD, 0);
        send(FUNC_LOAD, 255);
        repeat (4) send(FUNC_EMIT, 0);

        phase = 0;
        while (ordinary_reqs < ITEM_BUDGET) begin
            configure_phase(phase);
            calm   = (phase == 2 || phase == 3);
            frames = (phase == 1 || phase == 4) ? 1 : $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                run_frame(cut);
                if (cut) break;
            end
            phase++;
        end
        calm = 1'b0;

        drain();
        $display("Covered %0d requests in %0d phases with %0d register writes,",
                 ordinary_reqs, phase, cfg_writes);
        $display("%0d thresholded pixels over %0d complete frames, oversized widths included.",
                 sb.pixels_checked, sb.frames_done);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ati_pkg.sv
design/ati_istore.sv
design/adaptive_threshold_integral_core.sv
verif/tb_top.sv
